// File: rtl/rgu_pkg.sv
// shared types, constants and helpers for the rectangle geometry unit
package rgu_pkg;

    // coordinate width of every rectangle field
    localparam int COORD_BITS = 16;
    // internal width: enough for a sum of three coordinates and a difference
    localparam int WIDE_BITS  = COORD_BITS + 3;
    localparam int OP_BITS    = 3;

    // stream widths, fields packed from bit 0 up and padded to whole bytes
    localparam int S_FIELD_BITS = OP_BITS + 8 * COORD_BITS;
    localparam int S_DATA_BITS  = ((S_FIELD_BITS + 7) / 8) * 8;
    localparam int M_FIELD_BITS = 4 * COORD_BITS + 1;
    localparam int M_DATA_BITS  = ((M_FIELD_BITS + 7) / 8) * 8;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [WIDE_BITS-1:0]  wide_t;

    // saturation limits at internal width
    localparam wide_t W_MAX = wide_t'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
    localparam wide_t W_MIN = -W_MAX - wide_t'(1);

    typedef enum logic [OP_BITS-1:0] {
        OP_TEST   = 3'd0,
        OP_MOVE   = 3'd1,
        OP_CENTER = 3'd2,
        OP_UNION  = 3'd3,
        OP_CLIP   = 3'd4
    } op_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t w;
        coord_t h;
    } rect_t;

    // one request as held in the input stage
    typedef struct packed {
        logic [OP_BITS-1:0] op;
        rect_t              a;
        rect_t              b;
    } req_t;

    // one result as held in the output stage
    typedef struct packed {
        rect_t r;
        logic  overlap;
    } res_t;

    // sign extend a coordinate to internal width
    function automatic wide_t sx(input coord_t v);
        return {{(WIDE_BITS - COORD_BITS){v[COORD_BITS-1]}}, v};
    endfunction

    // clamp an internal value to the coordinate range
    function automatic coord_t sat(input wide_t v);
        wide_t t;
        t = v;
        if (t > W_MAX) begin
            t = W_MAX;
        end
        if (t < W_MIN) begin
            t = W_MIN;
        end
        return t[COORD_BITS-1:0];
    endfunction

endpackage

// File: rtl/rectangle_geometry_unit_core.sv
// rectangle geometry unit: input register, datapath, result register
// path: an accepted request is held in the input register, and its result is then held in the result register
// throughput: one request per cycle unless m_tready stalls the result stage; an empty input stage loads even then
// the critical path is an add, a compare, a subtract, the result select and saturation
// reset: aresetn low empties both stages; payload registers are not cleared
module rectangle_geometry_unit_core
    import rgu_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // opcode, a_left, a_top, a_width, a_height, b_left, b_top, b_width, b_height
    input  logic [S_DATA_BITS-1:0] s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // res_left, res_top, res_width, res_height, overlap
    output logic [M_DATA_BITS-1:0] m_tdata
);

    localparam int C = COORD_BITS;

    logic in_valid_reg, in_valid_next;
    logic m_valid_reg, m_valid_next;
    req_t req_reg;
    res_t res_reg;
    res_t res_calc;
    req_t req_in;
    logic out_load, s_fire;

    // unpack request fields
    assign req_in.op  = s_tdata[OP_BITS-1:0];
    assign req_in.a.x = s_tdata[OP_BITS + 0*C +: C];
    assign req_in.a.y = s_tdata[OP_BITS + 1*C +: C];
    assign req_in.a.w = s_tdata[OP_BITS + 2*C +: C];
    assign req_in.a.h = s_tdata[OP_BITS + 3*C +: C];
    assign req_in.b.x = s_tdata[OP_BITS + 4*C +: C];
    assign req_in.b.y = s_tdata[OP_BITS + 5*C +: C];
    assign req_in.b.w = s_tdata[OP_BITS + 6*C +: C];
    assign req_in.b.h = s_tdata[OP_BITS + 7*C +: C];

    // stage flow control
    assign out_load = !m_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || out_load;
    assign s_fire   = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (out_load) begin
            in_valid_next = 1'b0;
        end
        m_valid_next = out_load ? in_valid_reg : m_valid_reg;
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // input stage payload
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            req_reg <= req_in;
        end
    end

    rgu_alu u_alu (
        .req (req_reg),
        .res (res_calc)
    );

    // result stage payload
    always_ff @(posedge aclk) begin
        if (out_load && in_valid_reg) begin
            res_reg <= res_calc;
        end
    end

    // pack result
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_DATA_BITS - M_FIELD_BITS){1'b0}}, res_reg.overlap,
                       res_reg.r.h, res_reg.r.w, res_reg.r.y, res_reg.r.x};

    // reset empties both stages
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (!m_tvalid && !in_valid_reg))
        else $error("stages not empty after reset");

    // an accepted request lands in the input stage
    a_accept_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> in_valid_reg)
        else $error("accepted request lost");

    // a full input stage moving on yields a valid result
    a_stage_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_load) |=> m_tvalid)
        else $error("result missing after stage advance");

    // intersect test gives a zero rectangle
    a_test_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_load && (req_reg.op == OP_TEST))
        |=> (m_tdata[4*C-1:0] == '0))
        else $error("intersect test rectangle not zero");

endmodule

// File: rtl/rgu_alu.sv
// combinational rectangle datapath: overlap test, move in, center, union, clip
module rgu_alu
    import rgu_pkg::*;
(
    input  req_t req,
    output res_t res
);

    wide_t ax, ay, aw, ah, bx, by, bw, bh;
    wide_t ax1, ay1, bx1, by1;
    logic  a_empty, b_empty, hit;

    assign ax = sx(req.a.x);
    assign ay = sx(req.a.y);
    assign aw = sx(req.a.w);
    assign ah = sx(req.a.h);
    assign bx = sx(req.b.x);
    assign by = sx(req.b.y);
    assign bw = sx(req.b.w);
    assign bh = sx(req.b.h);

    // far edges
    assign ax1 = ax + aw;
    assign ay1 = ay + ah;
    assign bx1 = bx + bw;
    assign by1 = by + bh;

    // emptiness and intersect test
    assign a_empty = (aw <= wide_t'(0)) || (ah <= wide_t'(0));
    assign b_empty = (bw <= wide_t'(0)) || (bh <= wide_t'(0));
    assign hit = !a_empty && !b_empty && (ax1 > bx) && (ax < bx1) && (ay1 > by) && (ay < by1);

    // move in: upper limit checked first, so it wins over the lower clamp
    wide_t mx_hi, my_hi, mx, my;
    assign mx_hi = bx1 - aw;
    assign my_hi = by1 - ah;
    assign mx = (ax > mx_hi) ? mx_hi : ((ax < bx) ? bx : ax);
    assign my = (ay > my_hi) ? my_hi : ((ay < by) ? by : ay);

    // center: halve the size difference, rounding toward zero
    wide_t dx, dy, dxn, dyn, cx, cy;
    assign dx  = bw - aw;
    assign dy  = bh - ah;
    assign dxn = dx + wide_t'({{(WIDE_BITS - 1){1'b0}}, dx[WIDE_BITS-1]});
    assign dyn = dy + wide_t'({{(WIDE_BITS - 1){1'b0}}, dy[WIDE_BITS-1]});
    assign cx  = dxn >>> 1;
    assign cy  = dyn >>> 1;

    // bounding box of both
    wide_t ux0, uy0, ux1, uy1;
    assign ux0 = (ax < bx) ? ax : bx;
    assign uy0 = (ay < by) ? ay : by;
    assign ux1 = (ax1 > bx1) ? ax1 : bx1;
    assign uy1 = (ay1 > by1) ? ay1 : by1;

    // overlapping region
    wide_t kx0, ky0, kx1, ky1;
    assign kx0 = (ax > bx) ? ax : bx;
    assign ky0 = (ay > by) ? ay : by;
    assign kx1 = (ax1 < bx1) ? ax1 : bx1;
    assign ky1 = (ay1 < by1) ? ay1 : by1;

    // result select and saturation
    always_comb begin
        wide_t rx, ry, rw, rh;
        rx = '0;
        ry = '0;
        rw = '0;
        rh = '0;
        unique case (op_t'(req.op))
            OP_MOVE: begin
                rx = mx;
                ry = my;
                rw = aw;
                rh = ah;
            end
            OP_CENTER: begin
                rx = cx;
                ry = cy;
                rw = aw;
                rh = ah;
            end
            OP_UNION: begin
                if (a_empty) begin
                    rx = bx;
                    ry = by;
                    rw = bw;
                    rh = bh;
                end else if (b_empty) begin
                    rx = ax;
                    ry = ay;
                    rw = aw;
                    rh = ah;
                end else begin
                    rx = ux0;
                    ry = uy0;
                    rw = ux1 - ux0;
                    rh = uy1 - uy0;
                end
            end
            OP_CLIP: begin
                if (hit) begin
                    rx = kx0;
                    ry = ky0;
                    rw = kx1 - kx0;
                    rh = ky1 - ky0;
                end
            end
            default: begin
                // intersect test and unused codes give a zero rectangle
                rx = '0;
            end
        endcase
        res.r.x     = sat(rx);
        res.r.y     = sat(ry);
        res.r.w     = sat(rw);
        res.r.h     = sat(rh);
        res.overlap = hit;
    end

endmodule

// File: test/rectangle_geometry_unit_core_checker.sv
// checker for the rectangle geometry unit: predicts each result and compares it
`timescale 1ns / 100ps

module rectangle_geometry_unit_core_checker
    import rgu_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    // opcode, a_left, a_top, a_width, a_height, b_left, b_top, b_width, b_height
    input  logic [S_DATA_BITS-1:0] s_tdata,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    // res_left, res_top, res_width, res_height, overlap
    input  logic [M_DATA_BITS-1:0] m_tdata,
    output int                     mismatch_count,
    output int                     rects_in_flight
);

    // coordinate range as wide values
    localparam longint COORD_HI = (longint'(1) <<< (COORD_BITS - 1)) - 1;
    localparam longint COORD_LO = -COORD_HI - 1;

    typedef struct {
        coord_t left;
        coord_t top;
        coord_t width;
        coord_t height;
        logic   overlap;
    } rect_result_t;

    rect_result_t expected_rects[$];
    int           mismatch_total = 0;

    assign mismatch_count = mismatch_total;

    // one line per mismatch, all of them counted
    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        mismatch_total++;
    endtask

    // signed coordinate number idx of a request, widened
    function automatic longint coord_field(input logic [S_DATA_BITS-1:0] d, input int idx);
        coord_t c;
        c = d[OP_BITS + idx * COORD_BITS +: COORD_BITS];
        return longint'(c);
    endfunction

    // saturate a wide value into the coordinate range
    function automatic coord_t clamp_coord(input longint v);
        longint t;
        t = v;
        if (t > COORD_HI) begin
            t = COORD_HI;
        end
        if (t < COORD_LO) begin
            t = COORD_LO;
        end
        return coord_t'(t);
    endfunction

    // expected result of one request
    function automatic rect_result_t predict_rect(input logic [S_DATA_BITS-1:0] d);
        logic [OP_BITS-1:0] op;
        longint             ax, ay, aw, ah, bx, by, bw, bh;
        longint             rx, ry, rw, rh, hi_x, hi_y;
        logic               a_void, b_void, hit;
        rect_result_t       res;
        op = d[OP_BITS-1:0];
        ax = coord_field(d, 0);
        ay = coord_field(d, 1);
        aw = coord_field(d, 2);
        ah = coord_field(d, 3);
        bx = coord_field(d, 4);
        by = coord_field(d, 5);
        bw = coord_field(d, 6);
        bh = coord_field(d, 7);
        a_void = (aw <= 0) || (ah <= 0);
        b_void = (bw <= 0) || (bh <= 0);
        hit = !a_void && !b_void && (ax + aw > bx) && (ax < bx + bw)
              && (ay + ah > by) && (ay < by + bh);
        rx = 0;
        ry = 0;
        rw = 0;
        rh = 0;
        case (op)
            OP_MOVE: begin
                // upper bound is checked first, so it wins when it is exceeded
                hi_x = bx + bw - aw;
                hi_y = by + bh - ah;
                if (ax > hi_x) rx = hi_x;
                else if (ax < bx) rx = bx;
                else rx = ax;
                if (ay > hi_y) ry = hi_y;
                else if (ay < by) ry = by;
                else ry = ay;
                rw = aw;
                rh = ah;
            end
            OP_CENTER: begin
                // integer division truncates toward zero
                rx = (bw - aw) / 2;
                ry = (bh - ah) / 2;
                rw = aw;
                rh = ah;
            end
            OP_UNION: begin
                if (a_void) begin
                    rx = bx; ry = by; rw = bw; rh = bh;
                end else if (b_void) begin
                    rx = ax; ry = ay; rw = aw; rh = ah;
                end else begin
                    rx = (ax < bx) ? ax : bx;
                    ry = (ay < by) ? ay : by;
                    rw = ((ax + aw > bx + bw) ? ax + aw : bx + bw) - rx;
                    rh = ((ay + ah > by + bh) ? ay + ah : by + bh) - ry;
                end
            end
            OP_CLIP: begin
                if (hit) begin
                    rx = (ax > bx) ? ax : bx;
                    ry = (ay > by) ? ay : by;
                    rw = ((ax + aw < bx + bw) ? ax + aw : bx + bw) - rx;
                    rh = ((ay + ah < by + bh) ? ay + ah : by + bh) - ry;
                end
            end
            default: begin
                // intersect test and unused codes leave the rectangle at zero
            end
        endcase
        res.left    = clamp_coord(rx);
        res.top     = clamp_coord(ry);
        res.width   = clamp_coord(rw);
        res.height  = clamp_coord(rh);
        res.overlap = hit;
        return res;
    endfunction

    // watch both channels: compare results first, then queue new requests
    always @(posedge aclk) begin : watch
        rect_result_t got;
        rect_result_t want;
        if (!aresetn) begin
            expected_rects.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got.left    = m_tdata[0 * COORD_BITS +: COORD_BITS];
                got.top     = m_tdata[1 * COORD_BITS +: COORD_BITS];
                got.width   = m_tdata[2 * COORD_BITS +: COORD_BITS];
                got.height  = m_tdata[3 * COORD_BITS +: COORD_BITS];
                got.overlap = m_tdata[4 * COORD_BITS];
                if (expected_rects.size() == 0) begin
                    report_mismatch($sformatf("result with no request outstanding: %h", m_tdata));
                end else begin
                    want = expected_rects.pop_front();
                    if (got.left !== want.left) begin
                        report_mismatch($sformatf("res_left got %0d expected %0d",
                                                  got.left, want.left));
                    end
                    if (got.top !== want.top) begin
                        report_mismatch($sformatf("res_top got %0d expected %0d",
                                                  got.top, want.top));
                    end
                    if (got.width !== want.width) begin
                        report_mismatch($sformatf("res_width got %0d expected %0d",
                                                  got.width, want.width));
                    end
                    if (got.height !== want.height) begin
                        report_mismatch($sformatf("res_height got %0d expected %0d",
                                                  got.height, want.height));
                    end
                    if (got.overlap !== want.overlap) begin
                        report_mismatch($sformatf("overlap got %b expected %b",
                                                  got.overlap, want.overlap));
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                expected_rects.push_back(predict_rect(s_tdata));
            end
        end
        rects_in_flight <= expected_rects.size();
    end

endmodule

// File: test/rectangle_geometry_unit_core_tb.sv
// testbench top for the rectangle geometry unit: stimulus, pacing and verdict
`timescale 1ns / 100ps

module rectangle_geometry_unit_core_tb
    import rgu_pkg::*;
();

    localparam int          RANDOM_ITEMS = 1700;
    localparam int          CYCLE_LIMIT  = 1000000;
    localparam int          DRAIN_CYCLES = 10;
    // opcodes with no operation of their own
    localparam logic [OP_BITS-1:0] OP_RSVD5 = 3'd5;
    localparam logic [OP_BITS-1:0] OP_RSVD6 = 3'd6;
    localparam logic [OP_BITS-1:0] OP_RSVD7 = 3'd7;
    localparam coord_t C_MAX = {1'b0, {(COORD_BITS - 1){1'b1}}};
    localparam coord_t C_MIN = {1'b1, {(COORD_BITS - 1){1'b0}}};

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_DATA_BITS-1:0] s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_DATA_BITS-1:0] m_tdata;
    int                     mismatch_count;
    int                     rects_in_flight;
    int                     cycle_count = 0;
    bit                     sender_steady = 1'b0;

    always #6 aclk = ~aclk;

    rectangle_geometry_unit_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    rectangle_geometry_unit_core_checker checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .mismatch_count  (mismatch_count),
        .rects_in_flight (rects_in_flight)
    );

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("rectangle_geometry_unit_core_tb: done, errors");
            $finish;
        end
    end

    // idle length: mostly none or short, now and then long
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // coordinates at or next to the ends of the range, or around zero
    function automatic coord_t rand_extreme();
        case ($urandom_range(0, 6))
            0: return C_MIN;
            1: return coord_t'(C_MIN + 1);
            2: return -1;
            3: return 0;
            4: return 1;
            5: return coord_t'(C_MAX - 1);
            default: return C_MAX;
        endcase
    endfunction

    // position: 0 full range, 1 close to the origin, else extremes
    function automatic coord_t rand_pos(input int unsigned mode);
        case (mode)
            0: return coord_t'($urandom);
            1: return coord_t'(int'($urandom_range(0, 240)) - 120);
            default: return rand_extreme();
        endcase
    endfunction

    // size: like a position, but the near mode is mostly positive
    function automatic coord_t rand_size(input int unsigned mode);
        case (mode)
            0: return coord_t'($urandom);
            1: return coord_t'(int'($urandom_range(0, 80)) - 6);
            default: return rand_extreme();
        endcase
    endfunction

    // drive one request and hold it until it is taken
    task automatic send_rects(input logic [OP_BITS-1:0] op,
                              input coord_t ax, input coord_t ay,
                              input coord_t aw, input coord_t ah,
                              input coord_t bx, input coord_t by,
                              input coord_t bw, input coord_t bh);
        int unsigned            gap;
        logic [S_DATA_BITS-1:0] d;
        gap = sender_steady ? 0 : idle_len();
        d = '0;
        d[S_FIELD_BITS-1:0] = {bh, bw, by, bx, ah, aw, ay, ax, op};
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        do @(posedge aclk); while (!s_tready);
    endtask

    // result side pacing
    initial begin : sink_pacing
        int unsigned n;
        @(posedge aclk);
        forever begin
            if ($urandom_range(0, 19) == 0) begin
                // a stretch with no stall at all
                m_tready <= 1'b1;
                repeat ($urandom_range(100, 300)) @(posedge aclk);
            end else begin
                n = idle_len();
                if (n != 0) begin
                    m_tready <= 1'b0;
                    repeat (n) @(posedge aclk);
                end
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
        end
    end

    // stimulus and verdict
    initial begin : stimulus
        logic [OP_BITS-1:0] op;
        int unsigned        item_mode;
        int unsigned        fm [8];
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // intersect test: overlap, shared edge, empty operands
        send_rects(OP_TEST, 0, 0, 10, 10, 5, 5, 10, 10);
        send_rects(OP_TEST, 0, 0, 10, 10, 10, 0, 5, 5);
        send_rects(OP_TEST, 0, 0, 0, 10, 0, 0, 10, 10);
        send_rects(OP_TEST, 2, 2, 4, 4, 0, 0, 10, -3);
        send_rects(OP_TEST, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX);
        send_rects(OP_TEST, -1, -1, 1, 1, -1, -1, 1, 1);
        // move in: each bound, both conflict orders, saturation
        send_rects(OP_MOVE, -50, -50, 10, 10, 0, 0, 100, 100);
        send_rects(OP_MOVE, 500, 700, 10, 10, 0, 0, 100, 100);
        send_rects(OP_MOVE, 0, 0, 200, 200, 0, 0, 100, 100);
        send_rects(OP_MOVE, -300, -300, 200, 200, 0, 0, 100, 100);
        send_rects(OP_MOVE, C_MIN, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, C_MAX);
        // center in: truncation of negative odd halves, widest spans
        send_rects(OP_CENTER, 3, 4, 11, 7, 0, 0, 4, 2);
        send_rects(OP_CENTER, 0, 0, C_MIN, C_MIN, 0, 0, C_MAX, C_MAX);
        send_rects(OP_CENTER, 0, 0, C_MAX, C_MAX, 0, 0, C_MIN, C_MIN);
        // union: empty A, empty B, both empty, bounding box, overflow
        send_rects(OP_UNION, 1, 2, -5, 3, 10, 20, 30, 40);
        send_rects(OP_UNION, 1, 2, 5, 3, 10, 20, 30, 0);
        send_rects(OP_UNION, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN);
        send_rects(OP_UNION, 0, 0, 10, 10, 20, 30, 5, 5);
        send_rects(OP_UNION, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX);
        // clip: overlap, disjoint, whole range
        send_rects(OP_CLIP, 0, 0, 10, 10, 5, 5, 10, 10);
        send_rects(OP_CLIP, 0, 0, 10, 10, 20, 20, 5, 5);
        send_rects(OP_CLIP, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX, C_MAX);
        // unused codes still report overlap
        send_rects(OP_RSVD5, 0, 0, 10, 10, 5, 5, 10, 10);
        send_rects(OP_RSVD6, 0, 0, 10, 10, 5, 5, 10, 10);
        send_rects(OP_RSVD7, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX);

        // random requests, mostly nearby rectangles so that they interact
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 150 == 0) begin
                sender_steady = ($urandom_range(0, 3) == 0);
            end
            if ($urandom_range(0, 99) < 88) begin
                op = 3'($urandom_range(OP_TEST, OP_CLIP));
            end else begin
                op = 3'($urandom);
            end
            item_mode = $urandom_range(0, 99);
            if (item_mode < 55) item_mode = 1;
            else if (item_mode < 75) item_mode = 0;
            else if (item_mode < 85) item_mode = 2;
            else item_mode = 3;
            foreach (fm[k]) begin
                fm[k] = (item_mode == 3) ? $urandom_range(0, 2) : item_mode;
            end
            send_rects(op, rand_pos(fm[0]), rand_pos(fm[1]),
                       rand_size(fm[2]), rand_size(fm[3]),
                       rand_pos(fm[4]), rand_pos(fm[5]),
                       rand_size(fm[6]), rand_size(fm[7]));
        end
        s_tvalid <= 1'b0;

        // drain
        do @(posedge aclk); while (rects_in_flight != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && rects_in_flight == 0) begin
            $display("rectangle_geometry_unit_core_tb: done, clean");
        end else begin
            $display("rectangle_geometry_unit_core_tb: done, errors");
        end
        $finish;
    end

endmodule
